### hdl/decu_pkg.sv
// ----------------------------------------------------------------------------
// decu_pkg - shared constants for the descent engine control unit
// Throttle width default, register map, item kinds and trim codes.
// ----------------------------------------------------------------------------
package decu_pkg;

    // Throttle counts are steps of 0.00026828571 of full thrust.
    localparam int THROTTLE_BITS_DEF = 12;

    // Reset values of the limit registers: 0.825 and 0.925 of full thrust.
    localparam int AUTO_LIMIT_RST  = 3075;
    localparam int TOTAL_LIMIT_RST = 3448;

    // APB register map: register i at byte address 4*i.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_AUTO_LIMIT  = 1'b0;
    localparam logic REG_TOTAL_LIMIT = 1'b1;

    // Input item kinds.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PULSE = 1'b1;

    // Pulse word format: 15-bit ones' complement, sign in bit 14.
    localparam int PULSE_W   = 15;
    localparam int PULSE_SGN = 14;

    // Two's complement trim codes.
    localparam logic signed [1:0] TRIM_ZERO  = 2'sb00;
    localparam logic signed [1:0] TRIM_PLUS  = 2'sb01;
    localparam logic signed [1:0] TRIM_MINUS = 2'sb11;

endpackage

### hdl/decu_if.sv
// ----------------------------------------------------------------------------
// decu_in_if / decu_out_if - valid/ready channels of the control unit
// Input items (ticks and pulse words) and result items.
// ----------------------------------------------------------------------------
interface decu_in_if #(
    parameter int THROTTLE_BITS = decu_pkg::THROTTLE_BITS_DEF
);
    import decu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [PULSE_W-1:0]       pulse_word;
    logic                     power_ok;
    logic                     arm_switch;
    logic                     pgns_mode;
    logic [3:0]               trim_bits;
    logic [1:0]               engine_bits;
    logic [1:0]               manual_buttons;
    logic                     auto_throttle;
    logic [THROTTLE_BITS-1:0] manual_throttle;
    logic [1:0]               gimbal_fail;

    modport source (
        output valid, cmd, pulse_word, power_ok, arm_switch, pgns_mode, trim_bits,
               engine_bits, manual_buttons, auto_throttle, manual_throttle,
               gimbal_fail,
        input  ready
    );

    modport sink (
        input  valid, cmd, pulse_word, power_ok, arm_switch, pgns_mode, trim_bits,
               engine_bits, manual_buttons, auto_throttle, manual_throttle,
               gimbal_fail,
        output ready
    );
endinterface

interface decu_out_if #(
    parameter int THROTTLE_BITS = decu_pkg::THROTTLE_BITS_DEF
);
    import decu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [1:0]        pitch_trim;
    logic signed [1:0]        roll_trim;
    logic                     engine_arm;
    logic                     thrust_on;
    logic                     thrust_off;
    logic [THROTTLE_BITS-1:0] thrust_command;
    logic                     gimbal_fail_flag;
    logic                     powered_now;

    modport source (
        output valid, pitch_trim, roll_trim, engine_arm, thrust_on, thrust_off,
               thrust_command, gimbal_fail_flag, powered_now,
        input  ready
    );

    modport sink (
        input  valid, pitch_trim, roll_trim, engine_arm, thrust_on, thrust_off,
               thrust_command, gimbal_fail_flag, powered_now,
        output ready
    );
endinterface

### hdl/descent_engine_control_unit_core.sv
// ----------------------------------------------------------------------------
// descent_engine_control_unit_core - descent engine control unit
// Power, gimbal trim, engine arm/on/off and throttle from ticks and pulses.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per item. cmd = tick brings the switch,
//   channel and hand throttle inputs; cmd = pulse brings a 15-bit ones'
//   complement thrust pulse word that moves the auto-throttle accumulator
//   (only while powered, clamped to [0, auto_limit]).
//   o_out returns exactly one result transaction per input transaction,
//   in order. A pulse word repeats the drive outputs of the last tick.
//   The result is registered: o_out.valid rises in the cycle after input acceptance.
//   Throughput: one item per clock; the single output register frees up
//   in the same cycle it is taken, so i_in.ready = !valid || o_out.ready.
//   When the receiver stalls, the output register holds and i_in.ready
//   drops until the result is taken; no item is lost.
//   APB port: auto_limit at 0x0, total_limit at 0x4, zero wait states.
//   Write limits only while the unit is idle.
//   Reset (i_rst_n low, synchronous): unpowered, accumulator and trim
//   holds zero, drive outputs zero, limits back to 3075 and 3448 steps.
// ----------------------------------------------------------------------------
module descent_engine_control_unit_core #(
    parameter int THROTTLE_BITS = decu_pkg::THROTTLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    decu_in_if.sink                        i_in,
    decu_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [decu_pkg::PADDR_W-1:0]   paddr,
    input  logic [decu_pkg::PDATA_W-1:0]   pwdata,
    output logic [decu_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import decu_pkg::*;

    // Signed working width of the accumulator update: covers level +/- pulses.
    localparam int LVL_W = ((THROTTLE_BITS > PULSE_W) ? THROTTLE_BITS : PULSE_W) + 2;

    function automatic logic signed [1:0] axis_trim(input logic plus, input logic minus);
        logic signed [1:0] t;
        t = TRIM_ZERO;
        if (plus && !minus) t = TRIM_PLUS;
        if (minus && !plus) t = TRIM_MINUS;
        return t;
    endfunction

    // ---------------- configuration registers ----------------
    logic [THROTTLE_BITS-1:0] r_auto_limit;
    logic [THROTTLE_BITS-1:0] r_total_limit;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_limit  <= THROTTLE_BITS'(AUTO_LIMIT_RST);
            r_total_limit <= THROTTLE_BITS'(TOTAL_LIMIT_RST);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_AUTO_LIMIT:  r_auto_limit  <= pwdata[THROTTLE_BITS-1:0];
                REG_TOTAL_LIMIT: r_total_limit <= pwdata[THROTTLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_AUTO_LIMIT:  prdata = PDATA_W'(r_auto_limit);
            REG_TOTAL_LIMIT: prdata = PDATA_W'(r_total_limit);
            default:         prdata = '0;
        endcase
    end

    // ---------------- unit state ----------------
    logic                     r_powered,    n_powered;
    logic [THROTTLE_BITS-1:0] r_auto_level, n_auto_level;
    logic signed [1:0]        r_pitch_hold, n_pitch_hold;
    logic signed [1:0]        r_roll_hold,  n_roll_hold;

    // Drive outputs latched by the last tick.
    logic signed [1:0]        r_drv_pitch, n_drv_pitch;
    logic signed [1:0]        r_drv_roll,  n_drv_roll;
    logic                     r_drv_arm,   n_drv_arm;
    logic                     r_drv_on,    n_drv_on;
    logic                     r_drv_off,   n_drv_off;
    logic [THROTTLE_BITS-1:0] r_drv_thr,   n_drv_thr;

    logic                     n_fail;

    // Output register.
    logic                     r_out_valid;
    logic                     in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // ---------------- pulse word accumulation ----------------
    logic [PULSE_W-1:0]       pulse_mag;
    logic signed [LVL_W-1:0]  lvl_sum;
    logic [THROTTLE_BITS-1:0] lvl_clamped;

    always_comb begin
        // Ones' complement: negative words carry the inverted magnitude;
        // negative zero yields zero pulses.
        pulse_mag = i_in.pulse_word[PULSE_SGN] ? ~i_in.pulse_word : i_in.pulse_word;
        if (i_in.pulse_word[PULSE_SGN]) begin
            lvl_sum = $signed(LVL_W'(r_auto_level)) - $signed(LVL_W'(pulse_mag));
        end else begin
            lvl_sum = $signed(LVL_W'(r_auto_level)) + $signed(LVL_W'(pulse_mag));
        end
        if (lvl_sum < 0) begin
            lvl_clamped = '0;
        end else if (lvl_sum > $signed(LVL_W'(r_auto_limit))) begin
            lvl_clamped = r_auto_limit;
        end else begin
            lvl_clamped = lvl_sum[THROTTLE_BITS-1:0];
        end
    end

    // ---------------- tick evaluation ----------------
    logic [THROTTLE_BITS:0]   thr_sum;
    logic [THROTTLE_BITS-1:0] thr_auto;

    always_comb begin
        thr_sum  = {1'b0, r_auto_level} + {1'b0, i_in.manual_throttle};
        thr_auto = (thr_sum > {1'b0, r_total_limit}) ? r_total_limit
                                                     : thr_sum[THROTTLE_BITS-1:0];
    end

    always_comb begin
        n_powered    = r_powered;
        n_auto_level = r_auto_level;
        n_pitch_hold = r_pitch_hold;
        n_roll_hold  = r_roll_hold;
        n_drv_pitch  = r_drv_pitch;
        n_drv_roll   = r_drv_roll;
        n_drv_arm    = r_drv_arm;
        n_drv_on     = r_drv_on;
        n_drv_off    = r_drv_off;
        n_drv_thr    = r_drv_thr;
        n_fail       = 1'b0;

        case (i_in.cmd)
            CMD_PULSE: begin
                if (r_powered) n_auto_level = lvl_clamped;
            end
            CMD_TICK: begin
                n_powered = i_in.power_ok;
                if (!i_in.power_ok) begin
                    // Unpowered: drives drop, holds and accumulator keep.
                    n_drv_pitch = TRIM_ZERO;
                    n_drv_roll  = TRIM_ZERO;
                    n_drv_arm   = 1'b0;
                    n_drv_on    = 1'b0;
                    n_drv_off   = 1'b0;
                    n_drv_thr   = '0;
                end else begin
                    // Trim follows guidance only while armed; zero outside PGNS.
                    if (i_in.arm_switch) begin
                        if (i_in.pgns_mode) begin
                            n_pitch_hold = axis_trim(i_in.trim_bits[0], i_in.trim_bits[1]);
                            n_roll_hold  = axis_trim(i_in.trim_bits[2], i_in.trim_bits[3]);
                        end else begin
                            n_pitch_hold = TRIM_ZERO;
                            n_roll_hold  = TRIM_ZERO;
                        end
                    end
                    n_fail = |i_in.gimbal_fail;

                    // Guidance on/off, then manual start, then manual stop wins.
                    n_drv_on  = i_in.pgns_mode && i_in.engine_bits[0];
                    n_drv_off = i_in.pgns_mode && i_in.engine_bits[1];
                    if (i_in.manual_buttons[0]) begin
                        n_drv_on  = 1'b1;
                        n_drv_off = 1'b0;
                    end
                    if (i_in.manual_buttons[1]) begin
                        n_drv_on  = 1'b0;
                        n_drv_off = 1'b1;
                    end

                    if (i_in.auto_throttle) begin
                        n_drv_thr = thr_auto;
                    end else begin
                        n_drv_thr    = i_in.manual_throttle;
                        n_auto_level = '0;
                    end

                    n_drv_pitch = n_pitch_hold;
                    n_drv_roll  = n_roll_hold;
                    n_drv_arm   = i_in.arm_switch;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powered    <= 1'b0;
            r_auto_level <= '0;
            r_pitch_hold <= TRIM_ZERO;
            r_roll_hold  <= TRIM_ZERO;
            r_drv_pitch  <= TRIM_ZERO;
            r_drv_roll   <= TRIM_ZERO;
            r_drv_arm    <= 1'b0;
            r_drv_on     <= 1'b0;
            r_drv_off    <= 1'b0;
            r_drv_thr    <= '0;
        end else if (in_acc) begin
            r_powered    <= n_powered;
            r_auto_level <= n_auto_level;
            r_pitch_hold <= n_pitch_hold;
            r_roll_hold  <= n_roll_hold;
            r_drv_pitch  <= n_drv_pitch;
            r_drv_roll   <= n_drv_roll;
            r_drv_arm    <= n_drv_arm;
            r_drv_on     <= n_drv_on;
            r_drv_off    <= n_drv_off;
            r_drv_thr    <= n_drv_thr;
        end
    end

    // ---------------- result register ----------------
    logic signed [1:0]        r_out_pitch;
    logic signed [1:0]        r_out_roll;
    logic                     r_out_arm;
    logic                     r_out_on;
    logic                     r_out_off;
    logic [THROTTLE_BITS-1:0] r_out_thr;
    logic                     r_out_fail;
    logic                     r_out_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pitch <= n_drv_pitch;
            r_out_roll  <= n_drv_roll;
            r_out_arm   <= n_drv_arm;
            r_out_on    <= n_drv_on;
            r_out_off   <= n_drv_off;
            r_out_thr   <= n_drv_thr;
            r_out_fail  <= n_fail;
            r_out_pw    <= n_powered;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.pitch_trim       = r_out_pitch;
    assign o_out.roll_trim        = r_out_roll;
    assign o_out.engine_arm       = r_out_arm;
    assign o_out.thrust_on        = r_out_on;
    assign o_out.thrust_off       = r_out_off;
    assign o_out.thrust_command   = r_out_thr;
    assign o_out.gimbal_fail_flag = r_out_fail;
    assign o_out.powered_now      = r_out_pw;

endmodule

### dv/tb_descent_engine_control_unit_core.sv
// ----------------------------------------------------------------------------
// tb_descent_engine_control_unit_core - testbench of the descent engine unit
// Sends ticks and thrust pulse words through the valid/ready input channel,
// predicts each result with an in-bench model of the unit and checks every
// result transaction field by field. Limits are written over APB between
// phases and read back. Both channels idle at random but in the last phase.
// ----------------------------------------------------------------------------
module tb_descent_engine_control_unit_core;
    import decu_pkg::*;

    localparam int THR_W     = THROTTLE_BITS_DEF;
    localparam int MAX_CYCLE = 200000;   // several times the slowest legal run
    localparam int DRAIN_LAT = 3;        // output register latency plus margin

    // One input transaction as the bench sees it.
    typedef struct packed {
        logic              cmd;
        logic [PULSE_W-1:0] pulse;
        logic              power_ok;
        logic              arm;
        logic              pgns;
        logic [3:0]        trim;
        logic [1:0]        eng;
        logic [1:0]        btn;
        logic              auto_mode;
        logic [THR_W-1:0]  man;
        logic [1:0]        gfail;
    } t_decu_item;

    // One result transaction; also used to hold the last tick's drive outputs.
    typedef struct packed {
        logic signed [1:0] pitch;
        logic signed [1:0] roll;
        logic              arm;
        logic              on;
        logic              off;
        logic [THR_W-1:0]  thrust;
        logic              fail_flag;
        logic              powered;
    } t_decu_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    decu_in_if  #(.THROTTLE_BITS(THR_W)) in_ch ();
    decu_out_if #(.THROTTLE_BITS(THR_W)) out_ch ();

    descent_engine_control_unit_core #(.THROTTLE_BITS(THR_W)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow state of the unit, owned by the monitor process.
    // ------------------------------------------------------------------
    logic              unit_powered;
    logic [THR_W-1:0]  acc_level;      // auto-throttle accumulator
    logic signed [1:0] pitch_held;
    logic signed [1:0] roll_held;
    t_decu_result      last_drive;     // drive outputs of the last tick
    logic [THR_W-1:0]  lim_auto;
    logic [THR_W-1:0]  lim_total;

    t_decu_result      expected_q[$]; // results still owed by the unit
    int                err_cnt;
    int                n_ticks;
    int                n_pulses;
    int                n_results;
    int                cyc;
    bit                idle_on;        // random gaps and stalls enabled

    // Clock: period of 2.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit; a hang anywhere ends up here.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYCLE) begin
            $display("FAIL descent_engine_control_unit_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Axis trim from a plus and a minus request; both or neither gives zero.
    function automatic logic signed [1:0] axis_code(input logic plus, input logic minus);
        if (plus && !minus) return TRIM_PLUS;
        if (minus && !plus) return TRIM_MINUS;
        return TRIM_ZERO;
    endfunction

    // Advances the shadow state by one accepted item and returns its result.
    function automatic t_decu_result advance_unit(input t_decu_item it);
        t_decu_result     r;
        int               lvl;
        logic [PULSE_W-1:0] mag;
        logic [THR_W:0]   sum;
        logic [THR_W-1:0] thr;
        logic             on_c;
        logic             off_c;
        r = '0;
        if (it.cmd == CMD_PULSE) begin
            // Pulses move the accumulator only while powered. The ones'
            // complement magnitude of a negative word is its inverse, so
            // negative zero subtracts nothing.
            if (unit_powered) begin
                lvl = int'(acc_level);
                if (it.pulse[PULSE_SGN]) begin
                    mag = ~it.pulse;
                    lvl = lvl - int'(mag);
                end else begin
                    lvl = lvl + int'(it.pulse);
                end
                if (lvl < 0) lvl = 0;
                if (lvl > int'(lim_auto)) lvl = int'(lim_auto);
                acc_level = lvl[THR_W-1:0];
            end
            r = last_drive;
            r.fail_flag = 1'b0;
            r.powered = unit_powered;
            return r;
        end

        unit_powered = it.power_ok;
        if (!unit_powered) begin
            // Unpowered: all drive outputs drop; holds and accumulator stay.
            last_drive = '0;
            return '0;
        end

        // Trim holds update only when armed; outside guidance they clear.
        if (it.arm) begin
            if (it.pgns) begin
                pitch_held = axis_code(it.trim[0], it.trim[1]);
                roll_held  = axis_code(it.trim[2], it.trim[3]);
            end else begin
                pitch_held = TRIM_ZERO;
                roll_held  = TRIM_ZERO;
            end
        end

        // Guidance bits count only in guidance mode; stop beats start.
        on_c  = it.pgns && it.eng[0];
        off_c = it.pgns && it.eng[1];
        if (it.btn[0]) begin
            on_c  = 1'b1;
            off_c = 1'b0;
        end
        if (it.btn[1]) begin
            on_c  = 1'b0;
            off_c = 1'b1;
        end

        if (it.auto_mode) begin
            sum = {1'b0, acc_level} + {1'b0, it.man};
            thr = (sum > {1'b0, lim_total}) ? lim_total : sum[THR_W-1:0];
        end else begin
            thr = it.man;
            acc_level = '0;
        end

        last_drive.pitch     = pitch_held;
        last_drive.roll      = roll_held;
        last_drive.arm       = it.arm;
        last_drive.on        = on_c;
        last_drive.off       = off_c;
        last_drive.thrust    = thr;
        last_drive.fail_flag = 1'b0;
        last_drive.powered   = 1'b0;
        r = last_drive;
        r.fail_flag = |it.gfail;
        r.powered = 1'b1;
        return r;
    endfunction

    task automatic cmp_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks results, tracks register writes, predicts accepted
    // items. Everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_blk
        t_decu_result exp_r;
        t_decu_item   it;
        if (!i_rst_n) begin
            unit_powered = 1'b0;
            acc_level    = '0;
            pitch_held   = TRIM_ZERO;
            roll_held    = TRIM_ZERO;
            last_drive   = '0;
            lim_auto     = THR_W'(AUTO_LIMIT_RST);
            lim_total    = THR_W'(TOTAL_LIMIT_RST);
        end else begin
            // A result leaves first; it always belongs to an earlier item.
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no item outstanding");
                    err_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    n_results++;
                    cmp_field("pitch_trim", int'(exp_r.pitch), int'(out_ch.pitch_trim));
                    cmp_field("roll_trim", int'(exp_r.roll), int'(out_ch.roll_trim));
                    cmp_field("engine_arm", int'(exp_r.arm), int'(out_ch.engine_arm));
                    cmp_field("thrust_on", int'(exp_r.on), int'(out_ch.thrust_on));
                    cmp_field("thrust_off", int'(exp_r.off), int'(out_ch.thrust_off));
                    cmp_field("thrust_command", int'(exp_r.thrust),
                              int'(out_ch.thrust_command));
                    cmp_field("gimbal_fail_flag", int'(exp_r.fail_flag),
                              int'(out_ch.gimbal_fail_flag));
                    cmp_field("powered_now", int'(exp_r.powered),
                              int'(out_ch.powered_now));
                end
            end

            // Register writes land at the access edge.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_AUTO_LIMIT) lim_auto = pwdata[THR_W-1:0];
                else lim_total = pwdata[THR_W-1:0];
            end

            if (in_ch.valid && in_ch.ready) begin
                it.cmd       = in_ch.cmd;
                it.pulse     = in_ch.pulse_word;
                it.power_ok  = in_ch.power_ok;
                it.arm       = in_ch.arm_switch;
                it.pgns      = in_ch.pgns_mode;
                it.trim      = in_ch.trim_bits;
                it.eng       = in_ch.engine_bits;
                it.btn       = in_ch.manual_buttons;
                it.auto_mode = in_ch.auto_throttle;
                it.man       = in_ch.manual_throttle;
                it.gfail     = in_ch.gimbal_fail;
                if (it.cmd == CMD_PULSE) n_pulses++;
                else n_ticks++;
                expected_q.push_back(advance_unit(it));
            end
        end
    end

    // Receiver: ready drops in random bursts.
    initial begin : sink_blk
        int stall_len;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_len = $urandom_range(1, 6);
                out_ch.ready <= 1'b0;
                repeat (stall_len - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drives one item and returns at the edge that accepts it; valid stays
    // high so the next item can follow back to back.
    task automatic send_item(input t_decu_item it);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.cmd             <= it.cmd;
        in_ch.pulse_word      <= it.pulse;
        in_ch.power_ok        <= it.power_ok;
        in_ch.arm_switch      <= it.arm;
        in_ch.pgns_mode       <= it.pgns;
        in_ch.trim_bits       <= it.trim;
        in_ch.engine_bits     <= it.eng;
        in_ch.manual_buttons  <= it.btn;
        in_ch.auto_throttle   <= it.auto_mode;
        in_ch.manual_throttle <= it.man;
        in_ch.gimbal_fail     <= it.gfail;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stops sending and waits until every owed result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // One APB transfer: setup, then access. A read checks the register.
    task automatic apb_xfer(input logic is_write, input logic idx,
                            input logic [THR_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= is_write ? PDATA_W'(val) : '0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!is_write && prdata[THR_W-1:0] !== val) begin
            $error("prdata at 0x%0h: expected %0d, got %0d", {idx, 2'b00}, val,
                   prdata[THR_W-1:0]);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both limits with the unit idle and reads them back.
    task automatic set_limits(input logic [THR_W-1:0] a_lim, input logic [THR_W-1:0] t_lim);
        drain_results();
        apb_xfer(1'b1, REG_AUTO_LIMIT, a_lim);
        apb_xfer(1'b1, REG_TOTAL_LIMIT, t_lim);
        apb_xfer(1'b0, REG_AUTO_LIMIT, a_lim);
        apb_xfer(1'b0, REG_TOTAL_LIMIT, t_lim);
    endtask

    function automatic t_decu_item make_pulse(input logic [PULSE_W-1:0] word);
        t_decu_item it;
        it = '0;
        it.cmd = CMD_PULSE;
        it.pulse = word;
        return it;
    endfunction

    function automatic t_decu_item make_tick(input logic pw, input logic arm,
                                             input logic pgns, input logic [3:0] trim,
                                             input logic [1:0] eng, input logic [1:0] btn,
                                             input logic auto_m, input logic [THR_W-1:0] man,
                                             input logic [1:0] gf);
        t_decu_item it;
        it = '0;
        it.cmd       = CMD_TICK;
        it.power_ok  = pw;
        it.arm       = arm;
        it.pgns      = pgns;
        it.trim      = trim;
        it.eng       = eng;
        it.btn       = btn;
        it.auto_mode = auto_m;
        it.man       = man;
        it.gfail     = gf;
        return it;
    endfunction

    // Random item. Mostly armed, auto-mode ticks, powered at power_pct percent,
    // mixed with pulse words so the accumulator walks its whole range; the
    // fields of the other kind carry random noise.
    function automatic t_decu_item rand_item(input int pulse_pct, input int power_pct);
        t_decu_item it;
        it.cmd       = ($urandom_range(0, 99) < pulse_pct) ? CMD_PULSE : CMD_TICK;
        case ($urandom_range(0, 5))
            0, 1:    it.pulse = PULSE_W'($urandom_range(0, 32767));
            2:       it.pulse = PULSE_W'($urandom_range(0, 600));
            3:       it.pulse = ~PULSE_W'($urandom_range(0, 600));
            4:       it.pulse = PULSE_W'($urandom_range(1000, 16383));
            default: it.pulse = '1;   // negative zero
        endcase
        it.power_ok  = $urandom_range(0, 99) < power_pct;
        it.arm       = $urandom_range(0, 99) < 80;
        it.pgns      = $urandom_range(0, 99) < 75;
        it.trim      = 4'($urandom_range(0, 15));
        it.eng       = 2'($urandom_range(0, 3));
        it.btn       = ($urandom_range(0, 9) < 7) ? 2'b00 : 2'($urandom_range(0, 3));
        it.auto_mode = $urandom_range(0, 99) < 80;
        it.man       = ($urandom_range(0, 1) == 0) ? THR_W'($urandom_range(0, 600))
                                                   : THR_W'($urandom_range(0, 4095));
        it.gfail     = ($urandom_range(0, 9) < 8) ? 2'b00 : 2'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic logic [THR_W-1:0] rand_limit();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return THR_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every case of the unit once, at the reset limits.
    task automatic test_directed_cases();
        send_item(make_pulse(15'h3FFF));       // pulse while unpowered: ignored
        send_item(make_tick(1'b0, 1'b1, 1'b1, 4'hF, 2'b11, 2'b11, 1'b1, '1, 2'b11));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b1001, 2'b01, 2'b00, 1'b1, '0, 2'b00));
        send_item(make_pulse(15'h3FFF));       // largest push, clamps at auto_limit
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0110, 2'b10, 2'b00, 1'b1, '1, 2'b00));
        send_item(make_pulse(15'h7FFF));       // negative zero
        send_item(make_pulse(15'h4000));       // largest pull, clamps at zero
        // both bits of each axis; start beats guidance off; pitch actuator fail
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'hF, 2'b11, 2'b01, 1'b1, 12'd200, 2'b01));
        // stop beats start; roll actuator fail
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0101, 2'b00, 2'b11, 1'b1, 12'd5, 2'b10));
        // disarmed: trim holds stay
        send_item(make_tick(1'b1, 1'b0, 1'b1, 4'b1010, 2'b01, 2'b00, 1'b1, 12'd7, 2'b00));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b1010, 2'b00, 2'b00, 1'b1, 12'd7, 2'b00));
        send_item(make_tick(1'b1, 1'b0, 1'b0, 4'b0101, 2'b11, 2'b00, 1'b1, 12'd8, 2'b00));
        // armed outside guidance: holds clear, guidance bits ignored
        send_item(make_tick(1'b1, 1'b1, 1'b0, 4'b0101, 2'b11, 2'b00, 1'b1, 12'd9, 2'b11));
        send_item(make_pulse(15'd1234));
        // manual mode: hand throttle unclamped, accumulator cleared
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0001, 2'b00, 2'b00, 1'b0, '1, 2'b00));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0000, 2'b00, 2'b00, 1'b1, '0, 2'b00));
        send_item(make_pulse(15'd1));
        send_item(make_pulse(~15'd1));
        // unpowered again: pulse is dropped and reports unpowered
        send_item(make_tick(1'b0, 1'b0, 1'b0, 4'b0000, 2'b00, 2'b00, 1'b1, 12'd3, 2'b01));
        send_item(make_pulse(15'd500));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0000, 2'b00, 2'b00, 1'b1, '0, 2'b00));
    endtask

    // Limits at both extremes, and a lowered auto limit over a high level.
    task automatic test_limit_extremes();
        set_limits('0, '0);
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0001, 2'b01, 2'b00, 1'b1, '1, 2'b00));
        send_item(make_pulse(15'h3FFF));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0001, 2'b01, 2'b00, 1'b1, 12'd100, 2'b00));
        set_limits('1, '1);
        send_item(make_pulse(15'h3FFF));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0100, 2'b01, 2'b00, 1'b1, '1, 2'b00));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b0100, 2'b01, 2'b00, 1'b1, '0, 2'b00));
        send_item(make_pulse(~15'd95));
        // level 4000 stays above the new ceiling until the next pulse word
        set_limits(12'd100, '1);
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b1000, 2'b00, 2'b00, 1'b1, '0, 2'b00));
        send_item(make_pulse(15'd0));
        send_item(make_tick(1'b1, 1'b1, 1'b1, 4'b1000, 2'b00, 2'b00, 1'b1, 12'd1, 2'b00));
        set_limits(THR_W'(AUTO_LIMIT_RST), THR_W'(TOTAL_LIMIT_RST));
    endtask

    // Well-formed traffic under several limit settings, then a noisy phase
    // with frequent power loss.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 5; ph++) begin
            set_limits(rand_limit(), rand_limit());
            repeat (75) send_item(rand_item(40, 92));
        end
        set_limits(rand_limit(), rand_limit());
        repeat (50) send_item(rand_item(50, 50));
    endtask

    // Closing stretch at full rate, no gaps and no stalls.
    task automatic test_full_rate();
        drain_results();
        idle_on = 1'b0;
        set_limits(THR_W'($urandom_range(1500, 4095)), THR_W'($urandom_range(2000, 4095)));
        repeat (100) send_item(rand_item(40, 95));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_ch.valid           = 1'b0;
        in_ch.cmd             = CMD_TICK;
        in_ch.pulse_word      = '0;
        in_ch.power_ok        = 1'b0;
        in_ch.arm_switch      = 1'b0;
        in_ch.pgns_mode       = 1'b0;
        in_ch.trim_bits       = '0;
        in_ch.engine_bits     = '0;
        in_ch.manual_buttons  = '0;
        in_ch.auto_throttle   = 1'b0;
        in_ch.manual_throttle = '0;
        in_ch.gimbal_fail     = '0;
        err_cnt   = 0;
        n_ticks   = 0;
        n_pulses  = 0;
        n_results = 0;
        cyc       = 0;
        idle_on   = 1'b1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_limit_extremes();
        test_random_traffic();
        test_full_rate();

        // Let the last result drain, then wait DRAIN_LAT more for stragglers.
        drain_results();
        repeat (DRAIN_LAT) @(posedge i_clk);

        $display("Ran %0d ticks and %0d pulse words, %0d results checked,",
                 n_ticks, n_pulses, n_results);
        $display("limits swept through zero, full scale and random values.");
        if (err_cnt == 0) begin
            $display("PASS descent_engine_control_unit_core");
        end else begin
            $display("FAIL descent_engine_control_unit_core");
        end
        $finish;
    end

endmodule

### descent_engine_control_unit_core.f
hdl/decu_pkg.sv
hdl/decu_if.sv
hdl/descent_engine_control_unit_core.sv
dv/tb_descent_engine_control_unit_core.sv
